/* src/xde_pkg.sv */
// xde_pkg: widths, limits and beat types shared by the delay estimator
// no dependencies
package xde_pkg;

  localparam int MAX_LAGS  = 64;
  localparam int LAG_W     = 6;
  localparam int SAMPLE_W  = 16;
  localparam int PROD_W    = 2 * SAMPLE_W;
  localparam int SUM_W     = 44;
  localparam int IN_DEPTH  = 4;
  localparam int OUT_DEPTH = 2;

  localparam logic [LAG_W-1:0] LAG_LIMIT_RESET = LAG_W'(63);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] reference_sample;
    logic signed [SAMPLE_W-1:0] measured_sample;
    logic                       last;
  } pair_t;

  typedef struct packed {
    logic        [LAG_W-1:0] delay;
    logic signed [SUM_W-1:0] peak_value;
  } result_t;

endpackage

/* src/xde_fifo.sv */
// xde_fifo: small register queue with push/full and pop/empty sides
// no package dependencies
module xde_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign dout    = mem[rp];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/xde_back.sv */
// xde_back: lag engine, one shared multiply-accumulate over the lag memories,
// then a peak search over the sums; uses xde_pkg
module xde_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [xde_pkg::LAG_W-1:0]   lag_limit,
  input  logic                        in_empty,
  input  xde_pkg::pair_t              in_data,
  output logic                        in_pop,
  input  logic                        res_full,
  output logic                        res_push,
  output xde_pkg::result_t            res_data
);

  localparam int LW = xde_pkg::LAG_W;
  localparam int SW = xde_pkg::SUM_W;
  localparam int NL = xde_pkg::MAX_LAGS;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MAC    = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_SRCH   = 3'd3;
  localparam logic [2:0] ST_SDRAIN = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};

  logic [2:0]    state;
  logic [LW-1:0] d;
  logic [LW-1:0] wp;
  logic [LW:0]   hcnt;
  logic [NL-1:0] svalid;
  logic signed [xde_pkg::SAMPLE_W-1:0] meas;
  logic          is_last;

  logic signed [xde_pkg::SAMPLE_W-1:0] hist_mem [NL];
  logic signed [SW-1:0]                sum_mem  [NL];
  logic signed [xde_pkg::SAMPLE_W-1:0] hist_q;
  logic signed [SW-1:0]                sum_q;

  logic          mac_issue;
  logic          srch_issue;
  logic [LW-1:0] haddr;
  logic [LW-1:0] top;

  logic          mv1;
  logic          sv1;
  logic [LW-1:0] d1;
  logic          hv1;
  logic          ok1;

  logic          mv2;
  logic [LW-1:0] d2;
  logic signed [xde_pkg::PROD_W-1:0] prod2;
  logic signed [SW-1:0]              old2;
  logic signed [xde_pkg::PROD_W-1:0] prod_raw;
  logic signed [xde_pkg::PROD_W-1:0] prod_c;
  logic signed [SW:0]                acc_c;
  logic signed [SW-1:0]              sat_c;

  logic signed [SW-1:0] cur;
  logic signed [SW-1:0] maxv;
  logic signed [SW-1:0] minv;
  logic [LW-1:0]        imax;
  logic [LW-1:0]        imin;
  logic [SW-1:0]        mag_max;
  logic [SW-1:0]        mag_min;
  logic                 pick_max;

  assign top = ({1'b0, lag_limit} > (LW+1)'(NL - 1)) ? LW'(NL - 1) : lag_limit;

  assign in_pop     = (state == ST_IDLE) && !in_empty;
  assign mac_issue  = (state == ST_MAC);
  assign srch_issue = (state == ST_SRCH);
  assign haddr      = wp - d;

  assign prod_raw = hist_q * meas;
  assign prod_c   = hv1 ? prod_raw : '0;
  assign acc_c  = {old2[SW-1], old2} + (SW+1)'(prod2);
  always_comb begin
    if (acc_c[SW] != acc_c[SW-1]) begin
      sat_c = acc_c[SW] ? SUM_MIN : SUM_MAX;
    end else begin
      sat_c = acc_c[SW-1:0];
    end
  end

  assign cur      = ok1 ? sum_q : '0;
  assign mag_max  = maxv[SW-1] ? SW'(-maxv) : SW'(maxv);
  assign mag_min  = minv[SW-1] ? SW'(-minv) : SW'(minv);
  assign pick_max = mag_max > mag_min;

  assign res_push            = (state == ST_EMIT) && !res_full;
  assign res_data.delay      = pick_max ? imax : imin;
  assign res_data.peak_value = pick_max ? maxv : minv;

  // lag memories
  always_ff @(posedge clk) begin
    if (in_pop) begin
      hist_mem[wp + 1'b1] <= in_data.reference_sample;
    end
    if (mv2) begin
      sum_mem[d2] <= sat_c;
    end
    hist_q <= hist_mem[haddr];
    sum_q  <= sum_mem[d];
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (in_pop) begin
      meas    <= in_data.measured_sample;
      is_last <= in_data.last;
    end
    d1    <= d;
    hv1   <= {1'b0, d} < hcnt;
    ok1   <= svalid[d];
    d2    <= d1;
    prod2 <= prod_c;
    old2  <= ok1 ? sum_q : '0;
    if (sv1) begin
      if (d1 == '0) begin
        maxv <= cur;
        imax <= d1;
        minv <= cur;
        imin <= d1;
      end else begin
        if (cur >= maxv) begin
          maxv <= cur;
          imax <= d1;
        end
        if (cur < minv) begin
          minv <= cur;
          imin <= d1;
        end
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      d      <= '0;
      wp     <= '0;
      hcnt   <= '0;
      svalid <= '0;
      mv1    <= 1'b0;
      sv1    <= 1'b0;
      mv2    <= 1'b0;
    end else begin
      mv1 <= mac_issue;
      sv1 <= srch_issue;
      mv2 <= mv1;
      if (mv2) begin
        svalid[d2] <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_pop) begin
            wp    <= wp + 1'b1;
            if (hcnt != (LW+1)'(NL)) begin
              hcnt <= hcnt + 1'b1;
            end
            d     <= '0;
            state <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (d == LW'(NL - 1)) begin
            state <= ST_DRAIN;
          end else begin
            d <= d + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!mv1 && !mv2) begin
            d     <= '0;
            state <= is_last ? ST_SRCH : ST_IDLE;
          end
        end
        ST_SRCH: begin
          if (d == top) begin
            state <= ST_SDRAIN;
          end else begin
            d <= d + 1'b1;
          end
        end
        ST_SDRAIN: begin
          if (!sv1) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!res_full) begin
            svalid <= '0;
            hcnt   <= '0;
            state  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/xcorr_delay_estimator.sv */
// xcorr_delay_estimator: top level, input queue, lag engine, result queue
// depends on xde_pkg, xde_fifo, xde_back
//
//   channel  | handshake          | payload
//   input    | push / full        | pair   (xde_pkg::pair_t)
//   result   | pop / empty        | result (xde_pkg::result_t)
//   config   | cfg_we             | cfg_data (lag_limit)
//
// in the lag engine each pair gets one multiply-accumulate per lag, over all MAX_LAGS lags,
// through the shared multiplier and sum memory port, plus pop and drain.
// a last pair adds a peak search over lags 0 to lag_limit and an emit state.
// reset clears the queues, the lag valid bits and sets lag_limit to 63.
// the input queue keeps taking beats while the engine works or the result waits.
module xcorr_delay_estimator #(
  parameter int IN_DEPTH  = xde_pkg::IN_DEPTH,
  parameter int OUT_DEPTH = xde_pkg::OUT_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  xde_pkg::pair_t            pair,
  output logic                      full,
  output logic                      empty,
  input  logic                      pop,
  output xde_pkg::result_t          result,
  input  logic                      cfg_we,
  input  logic [xde_pkg::LAG_W-1:0] cfg_data
);

  logic [xde_pkg::LAG_W-1:0] lag_limit;
  logic                      q_empty;
  logic                      q_pop;
  xde_pkg::pair_t            q_data;
  logic                      r_full;
  logic                      r_push;
  xde_pkg::result_t          r_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      lag_limit <= xde_pkg::LAG_LIMIT_RESET;
    end else if (cfg_we) begin
      lag_limit <= cfg_data;
    end
  end

  xde_fifo #(
    .W     ($bits(xde_pkg::pair_t)),
    .DEPTH (IN_DEPTH)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (pair),
    .full  (full),
    .pop   (q_pop),
    .dout  (q_data),
    .empty (q_empty)
  );

  xde_back u_back (
    .clk       (clk),
    .rst       (rst),
    .lag_limit (lag_limit),
    .in_empty  (q_empty),
    .in_data   (q_data),
    .in_pop    (q_pop),
    .res_full  (r_full),
    .res_push  (r_push),
    .res_data  (r_data)
  );

  xde_fifo #(
    .W     ($bits(xde_pkg::result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_result (
    .clk   (clk),
    .rst   (rst),
    .push  (r_push),
    .din   (r_data),
    .full  (r_full),
    .pop   (pop),
    .dout  (result),
    .empty (empty)
  );

endmodule

/* tb/xcorr_delay_estimator_tb.sv */
// xcorr_delay_estimator_tb: self-checking bench for the cross-correlation delay estimator
// predicts each block's peak lag and saturated sum, checks them on the result queue
// depends on xde_pkg and xcorr_delay_estimator
`timescale 1ns / 1ps

module xcorr_delay_estimator_tb;

  localparam int  NLAGS       = 64;
  localparam int  BLOCK_CAP   = 4096;
  localparam int  DRAIN_CYC   = 600;
  localparam int  CYCLE_LIMIT = 5_000_000;
  localparam longint SUM_HI   = 64'sd8796093022207;
  localparam longint SUM_LO   = -64'sd8796093022208;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      push = 1'b0;
  xde_pkg::pair_t            pair = '0;
  logic                      full;
  logic                      empty;
  logic                      pop = 1'b0;
  xde_pkg::result_t          result;
  logic                      cfg_we = 1'b0;
  logic [xde_pkg::LAG_W-1:0] cfg_data = '0;

  xcorr_delay_estimator u_top (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pair     (pair),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [xde_pkg::LAG_W-1:0] model_limit;
  int                        ref_hist [NLAGS];
  longint                    corr_sum [NLAGS];
  int                        block_pairs;
  xde_pkg::result_t          pending_peaks [$];

  int     fail_count = 0;
  int     results_seen = 0;
  int     pairs_sent = 0;
  int     blocks_sent = 0;
  int     cycle_count = 0;
  bit     no_gaps = 0;
  int     pop_hold = 0;

  function automatic void clear_corr();
    for (int d = 0; d < NLAGS; d++) begin
      ref_hist[d] = 0;
      corr_sum[d] = 0;
    end
    block_pairs = 0;
  endfunction

  function automatic void predict_pair(xde_pkg::pair_t p);
    longint           prod;
    longint           s;
    int               top;
    int               imax;
    int               imin;
    int               pick;
    longint           amax;
    longint           amin;
    xde_pkg::result_t r;
    for (int d = NLAGS - 1; d > 0; d--) ref_hist[d] = ref_hist[d-1];
    ref_hist[0] = int'(p.reference_sample);
    if (block_pairs < BLOCK_CAP) block_pairs++;
    for (int d = 0; d < NLAGS; d++) begin
      if (d < block_pairs) begin
        prod = longint'(ref_hist[d]) * longint'(int'(p.measured_sample));
        s = corr_sum[d] + prod;
        if (s > SUM_HI) s = SUM_HI;
        if (s < SUM_LO) s = SUM_LO;
        corr_sum[d] = s;
      end
    end
    if (p.last) begin
      top = int'(model_limit);
      if (top > NLAGS - 1) top = NLAGS - 1;
      imax = 0;
      imin = 0;
      for (int d = 1; d <= top; d++) begin
        if (corr_sum[d] >= corr_sum[imax]) imax = d;
        if (corr_sum[d] < corr_sum[imin]) imin = d;
      end
      amax = corr_sum[imax] < 0 ? -corr_sum[imax] : corr_sum[imax];
      amin = corr_sum[imin] < 0 ? -corr_sum[imin] : corr_sum[imin];
      pick = (amax > amin) ? imax : imin;
      r.delay = xde_pkg::LAG_W'(pick);
      r.peak_value = xde_pkg::SUM_W'(corr_sum[pick]);
      pending_peaks.push_back(r);
      clear_corr();
    end
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($urandom_range(0, 15)) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge with push left high
  task automatic send_pair(logic signed [15:0] r, logic signed [15:0] m, logic lst);
    int g;
    g = gap_len();
    if (g > 0) begin
      push = 1'b0;
      repeat (g) @(negedge clk);
    end
    push = 1'b1;
    pair.reference_sample = r;
    pair.measured_sample = m;
    pair.last = lst;
    do @(posedge clk); while (full);
    predict_pair(pair);
    pairs_sent++;
    if (lst) blocks_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    push = 1'b0;
    while (pending_peaks.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic set_lag_limit(logic [xde_pkg::LAG_W-1:0] v);
    wait_idle();
    cfg_we = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    model_limit = v;
  endtask

  task automatic send_block(int len);
    for (int i = 0; i < len; i++) send_pair(rand_sample(), rand_sample(), i == len - 1);
  endtask

  // result checker
  always @(posedge clk) begin
    xde_pkg::result_t want;
    if (!rst && pop && !empty) begin
      results_seen++;
      if (pending_peaks.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result beat: delay %0d peak %0d",
                                       result.delay, result.peak_value);
      end else begin
        want = pending_peaks.pop_front();
        if (result.delay !== want.delay || result.peak_value !== want.peak_value) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected delay %0d peak %0d, got delay %0d peak %0d",
                     want.delay, want.peak_value, result.delay, result.peak_value);
        end
      end
    end
  end

  // result side stalls
  always @(negedge clk) begin
    int r;
    if (rst) begin
      pop = 1'b0;
    end else if (pop_hold > 0) begin
      pop_hold--;
      pop = 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 12) pop_hold = $urandom_range(1, 3);
      else if (r < 16) pop_hold = $urandom_range(20, 150);
      pop = (pop_hold == 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_extremes();
    send_pair(16'sh7fff, 16'sh8000, 1'b1);
    send_pair(16'sh8000, 16'sh8000, 1'b0);
    send_pair(16'sh7fff, 16'sh7fff, 1'b0);
    send_pair(16'sh0000, 16'sh0001, 1'b1);
    send_pair(16'sh0000, 16'sh0000, 1'b1);
    send_pair(16'sh8000, 16'sh7fff, 1'b0);
    send_pair(16'shffff, 16'sh0001, 1'b1);
  endtask

  task automatic test_lag_limits();
    set_lag_limit(6'd0);
    send_pair(16'sh0100, 16'sh0000, 1'b0);
    send_pair(16'sh0000, 16'sh7fff, 1'b1);
    set_lag_limit(6'd1);
    send_pair(16'sh0100, 16'sh0000, 1'b0);
    send_pair(16'sh0000, 16'sh8000, 1'b1);
    set_lag_limit(6'd63);
  endtask

  task automatic test_limit_mid_block();
    send_pair(16'sh4000, 16'sh0000, 1'b0);
    send_pair(16'sh0000, 16'sh0000, 1'b0);
    send_pair(16'sh0000, 16'sh0000, 1'b0);
    set_lag_limit(6'd1);
    send_pair(16'sh0000, 16'sh7000, 1'b0);
    send_pair(16'sh0010, 16'sh0010, 1'b1);
    set_lag_limit(6'd63);
  endtask

  // long block of full-scale beats back to back, even lags up, odd lags down
  task automatic test_long_block();
    no_gaps = 1;
    for (int i = 0; i < 300; i++)
      send_pair(i[0] ? 16'sh7fff : 16'sh8000, i[0] ? 16'sh7fff : 16'sh8000, i == 299);
    no_gaps = 0;
  endtask

  task automatic test_random(int n_pairs);
    int sent;
    int len;
    int r;
    int nblk;
    sent = 0;
    nblk = 0;
    while (sent < n_pairs) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 16);
      else if (r < 95) len = $urandom_range(17, 80);
      else len = $urandom_range(81, 200);
      send_block(len);
      sent += len;
      nblk++;
      if (nblk % 8 == 0) begin
        r = $urandom_range(0, 3);
        set_lag_limit(r == 0 ? 6'd0 : r == 1 ? 6'd63 : 6'($urandom));
      end
    end
  endtask

  // pairs with no closing beat give no result
  task automatic test_unterminated();
    for (int i = 0; i < 5; i++) send_pair(rand_sample(), rand_sample(), 1'b0);
  endtask

  initial begin
    model_limit = xde_pkg::LAG_LIMIT_RESET;
    clear_corr();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_extremes();
    test_lag_limits();
    test_limit_mid_block();
    test_random(1100);
    set_lag_limit(6'd63);
    test_long_block();
    test_unterminated();
    wait_idle();
    $display("sent %0d pairs in %0d blocks, checked %0d results in %0d cycles",
             pairs_sent, blocks_sent, results_seen, cycle_count);
    $display("covered sample extremes, lag limits 0 to 63, mid-block limit change, long block");
    if (fail_count == 0 && pending_peaks.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending_peaks.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
src/xde_pkg.sv
src/xde_fifo.sv
src/xde_back.sv
src/xcorr_delay_estimator.sv
tb/xcorr_delay_estimator_tb.sv
